// ===== design/mahd_pkg.sv =====
`default_nettype none
package mahd_pkg;

  // header field codes
  localparam logic [1:0] VerMpeg25 = 2'd0;
  localparam logic [1:0] VerMpeg2  = 2'd2;
  localparam logic [1:0] VerMpeg1  = 2'd3;

  localparam logic [1:0] LayerIII = 2'd1;
  localparam logic [1:0] LayerII  = 2'd2;
  localparam logic [1:0] LayerI   = 2'd3;

  localparam int unsigned BrW  = 9;
  localparam int unsigned SrW  = 16;
  localparam int unsigned FbW  = 12;
  localparam int unsigned NumW = 26;
  localparam int unsigned CntW = $clog2(NumW);

  // bitrate in bit/s per kbit/s times the slot factor
  localparam logic [NumW-1:0] FactorL1  = NumW'(12000);
  localparam logic [NumW-1:0] FactorL23 = NumW'(144000);

  localparam logic [BrW-1:0] BrV1L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [BrW-1:0] BrV1L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [BrW-1:0] BrV1L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [BrW-1:0] BrV2L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [BrW-1:0] BrV2L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  localparam logic [SrW-1:0] BaseRate [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

  // one decoded header on its way to the divider
  typedef struct packed {
    logic            changed;
    logic            zero;
    logic            layer1;
    logic            pad;
    logic [BrW-1:0]  br;
    logic [SrW-1:0]  sr;
    logic [NumW-1:0] num;
  } cmd_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkOut
  } back_state_e;

  function automatic logic [BrW-1:0] lookup_bitrate(logic [1:0] ver, logic [1:0] lay,
                                                    logic [3:0] idx);
    logic [BrW-1:0] br;
    br = '0;
    case (ver)
      VerMpeg1: begin
        case (lay)
          LayerI:   br = BrV1L1[idx];
          LayerII:  br = BrV1L2[idx];
          LayerIII: br = BrV1L3[idx];
          default:  br = '0;
        endcase
      end
      VerMpeg2, VerMpeg25: begin
        case (lay)
          LayerI:            br = BrV2L1[idx];
          LayerII, LayerIII: br = BrV2L23[idx];
          default:           br = '0;
        endcase
      end
      default: br = '0;
    endcase
    return br;
  endfunction

endpackage
`default_nettype wire

// ===== design/mahd_front.sv =====
`default_nettype none
module mahd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [31:0]         header_word_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output mahd_pkg::cmd_t           q_data_o
);

  logic [22:0] last_hdr_q, last_hdr_d;
  logic [1:0]  ver, lay, sidx;
  logic [3:0]  bidx;
  logic        changed;
  logic [mahd_pkg::BrW-1:0]  br;
  logic [mahd_pkg::SrW-1:0]  base, sr;
  logic [mahd_pkg::NumW-1:0] factor;

  assign ver  = header_word_i[20:19];
  assign lay  = header_word_i[18:17];
  assign bidx = header_word_i[15:12];
  assign sidx = header_word_i[11:10];

  assign changed    = header_word_i[31:9] != last_hdr_q;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    br   = mahd_pkg::lookup_bitrate(ver, lay, bidx);
    base = mahd_pkg::BaseRate[sidx];
    case (ver)
      mahd_pkg::VerMpeg2:  sr = base >> 1;
      mahd_pkg::VerMpeg25: sr = base >> 2;
      default:             sr = base;
    endcase
    factor = (lay == mahd_pkg::LayerI) ? mahd_pkg::FactorL1 : mahd_pkg::FactorL23;
  end

  always_comb begin
    q_data_o.changed = changed;
    q_data_o.zero    = (br == '0) || (sr == '0);
    q_data_o.layer1  = lay == mahd_pkg::LayerI;
    q_data_o.pad     = header_word_i[9];
    q_data_o.br      = br;
    q_data_o.sr      = sr;
    q_data_o.num     = mahd_pkg::NumW'(br) * factor;
  end

  always_comb begin
    last_hdr_d = last_hdr_q;
    if (q_push_o && changed) begin
      last_hdr_d = header_word_i[31:9];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hdr_q <= '0;
    end else begin
      last_hdr_q <= last_hdr_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/mahd_fifo.sv =====
`default_nettype none
module mahd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mahd_pkg::cmd_t wr_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output mahd_pkg::cmd_t      rd_data_o,
  output logic                empty_o
);

  // two entries in flops
  mahd_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/mahd_back.sv =====
`default_nettype none
module mahd_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mahd_pkg::cmd_t             q_data_i,
  input  wire logic                       q_empty_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            changed_o,
  output logic [mahd_pkg::BrW-1:0]        bitrate_kbps_o,
  output logic [mahd_pkg::SrW-1:0]        sample_rate_hz_o,
  output logic [mahd_pkg::FbW-1:0]        frame_bytes_o
);

  mahd_pkg::back_state_e state_q, state_d;

  logic [mahd_pkg::CntW-1:0] cnt_q;
  logic [mahd_pkg::SrW-1:0]  rem_q, rem_d;
  logic [mahd_pkg::NumW-1:0] quo_q, quo_d;
  logic [mahd_pkg::SrW:0]    trial;
  logic                      ge;
  logic                      div_last;
  logic                      cur_layer1_q, cur_pad_q;
  logic [mahd_pkg::BrW-1:0]  cur_br_q;
  logic [mahd_pkg::SrW-1:0]  cur_sr_q;
  logic [mahd_pkg::FbW-1:0]  fb_sum, fb_final;

  logic [mahd_pkg::BrW-1:0]  last_br_q;
  logic [mahd_pkg::SrW-1:0]  last_sr_q;
  logic [mahd_pkg::FbW-1:0]  last_fb_q;

  logic                      out_chg_q;
  logic [mahd_pkg::BrW-1:0]  out_br_q;
  logic [mahd_pkg::SrW-1:0]  out_sr_q;
  logic [mahd_pkg::FbW-1:0]  out_fb_q;

  // one restoring step per cycle
  always_comb begin
    trial = {rem_q, quo_q[mahd_pkg::NumW-1]};
    ge    = trial >= {1'b0, cur_sr_q};
    rem_d = ge ? mahd_pkg::SrW'(trial - {1'b0, cur_sr_q}) : trial[mahd_pkg::SrW-1:0];
    quo_d = {quo_q[mahd_pkg::NumW-2:0], ge};
    fb_sum = quo_d[mahd_pkg::FbW-1:0] + mahd_pkg::FbW'(cur_pad_q);
    fb_final = cur_layer1_q ? {fb_sum[mahd_pkg::FbW-3:0], 2'b00} : fb_sum;
  end

  assign div_last = cnt_q == mahd_pkg::CntW'(mahd_pkg::NumW - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mahd_pkg::BkIdle: begin
        if (!q_empty_i) begin
          state_d = (q_data_i.changed && !q_data_i.zero) ? mahd_pkg::BkDiv : mahd_pkg::BkOut;
        end
      end
      mahd_pkg::BkDiv: begin
        if (div_last) state_d = mahd_pkg::BkOut;
      end
      mahd_pkg::BkOut: begin
        if (!out_stall_i) state_d = mahd_pkg::BkIdle;
      end
      default: state_d = mahd_pkg::BkIdle;
    endcase
  end

  always_comb begin
    q_pop_o     = (state_q == mahd_pkg::BkIdle) && !q_empty_i;
    out_valid_o = state_q == mahd_pkg::BkOut;
  end

  assign changed_o        = out_chg_q;
  assign bitrate_kbps_o   = out_br_q;
  assign sample_rate_hz_o = out_sr_q;
  assign frame_bytes_o    = out_fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mahd_pkg::BkIdle;
      last_br_q <= '0;
      last_sr_q <= '0;
      last_fb_q <= '0;
    end else begin
      state_q <= state_d;
      if (q_pop_o && q_data_i.changed && q_data_i.zero) begin
        last_br_q <= q_data_i.br;
        last_sr_q <= q_data_i.sr;
        last_fb_q <= '0;
      end else if (state_q == mahd_pkg::BkDiv && div_last) begin
        last_br_q <= cur_br_q;
        last_sr_q <= cur_sr_q;
        last_fb_q <= fb_final;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_layer1_q <= q_data_i.layer1;
      cur_pad_q    <= q_data_i.pad;
      cur_br_q     <= q_data_i.br;
      cur_sr_q     <= q_data_i.sr;
      rem_q        <= '0;
      quo_q        <= q_data_i.num;
      cnt_q        <= '0;
      out_chg_q    <= q_data_i.changed;
      if (!q_data_i.changed) begin
        out_br_q <= last_br_q;
        out_sr_q <= last_sr_q;
        out_fb_q <= last_fb_q;
      end else begin
        out_br_q <= q_data_i.br;
        out_sr_q <= q_data_i.sr;
        out_fb_q <= '0;
      end
    end else if (state_q == mahd_pkg::BkDiv) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q + mahd_pkg::CntW'(1);
      if (div_last) begin
        out_fb_q <= fb_final;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/mpeg_audio_header_decoder.sv =====
`default_nettype none
// channel  direction  handshake                 payload
// input    in         in_valid_i / in_stall_o   header_word_i
// output   out        out_valid_o / out_stall_i changed_o, bitrate_kbps_o,
//                                               sample_rate_hz_o, frame_bytes_o
//
// a changed, decodable header passes from input to output through the queue,
// the bit-serial divider and the output register; an unchanged or undecodable
// header skips the divider and goes from the queue to the output register
// a two-entry queue lets the front take items while the back divides or the
// output is stalled; the input stalls only when the queue is full
// reset clears the stored header and the stored decoded values to zero
module mpeg_audio_header_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] header_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             changed_o,
  output logic [8:0]       bitrate_kbps_o,
  output logic [15:0]      sample_rate_hz_o,
  output logic [11:0]      frame_bytes_o
);

  // front to queue
  mahd_pkg::cmd_t push_data, pop_data;
  logic           q_push, q_full;
  // queue to back
  logic           q_pop, q_empty;

  // front: compares with the stored header, decodes and forms the dividend
  mahd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .header_word_i (header_word_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (push_data)
  );

  // short queue decoupling front and back
  mahd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (push_data),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .rd_data_o (pop_data),
    .empty_o   (q_empty)
  );

  // back: divides, keeps the last decoded values and holds the result item
  mahd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_data_i         (pop_data),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .changed_o        (changed_o),
    .bitrate_kbps_o   (bitrate_kbps_o),
    .sample_rate_hz_o (sample_rate_hz_o),
    .frame_bytes_o    (frame_bytes_o)
  );

endmodule
`default_nettype wire

// ===== dv/mpeg_audio_header_decoder_test.sv =====
`default_nettype none
module mpeg_audio_header_decoder_test;

  // header codes that the package leaves unnamed
  localparam logic [1:0] VerReserved   = 2'd1;
  localparam logic [1:0] LayerReserved = 2'd0;

  localparam int unsigned RandomItems = 1330;
  localparam int unsigned IdlePercent = 32;
  // cycles with no item moving on either side before the run is abandoned
  localparam int unsigned StallLimit  = 2000;
  // outlasts a decodable header's way through the divider, so this covers the tail
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned ReportMax   = 10;

  // one result item as the block reports it
  typedef struct packed {
    logic        changed;
    logic [8:0]  kbps;
    logic [15:0] rate_hz;
    logic [11:0] bytes;
  } frame_info_t;

  // a result still owed by the block, with the header that caused it
  typedef struct packed {
    logic [31:0] word;
    frame_info_t info;
  } owed_frame_t;

  // one row of the directed part; fixed rows carry their result typed in
  typedef struct packed {
    logic [31:0] word;
    logic        fixed;
    frame_info_t info;
  } probe_t;

  // bitrate tables in kbit/s, indexed by the bitrate field
  localparam logic [8:0] KbpsV1L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KbpsV1L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KbpsV1L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KbpsV2L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KbpsV2L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
  localparam int unsigned RateHz [4] = '{44100, 48000, 32000, 0};

  // directed headers: reset state, extremes, every version and layer,
  // the reserved codes and the padding-only change
  localparam probe_t ProbeRows [21] = '{
    // all-zero header right after reset matches the cleared store
    '{32'h0000_0000, 1'b1, '{1'b0, 9'd0, 16'd0, 12'd0}},
    // bits 8..0 never count
    '{32'h0000_01FF, 1'b1, '{1'b0, 9'd0, 16'd0, 12'd0}},
    // mpeg-1 layer iii, 128 kbit/s, 44.1 khz
    '{32'hFFFB_9000, 1'b0, '0},
    // padding bit alone flips
    '{32'hFFFB_9200, 1'b0, '0},
    // same header, only the ignored low bits differ
    '{32'hFFFB_93FF, 1'b0, '0},
    // largest mpeg-1 layer i frame
    '{32'hFFFF_EA00, 1'b1, '{1'b1, 9'd448, 16'd32000, 12'd676}},
    // mpeg-1 layer ii
    '{32'hFFFD_E400, 1'b0, '0},
    // mpeg-2 layer i
    '{32'hFFF7_E800, 1'b0, '0},
    // mpeg-2 layer iii keeps the 144 factor
    '{32'hFFF3_9000, 1'b0, '0},
    // mpeg-2.5 layer iii with padding
    '{32'hFFE3_5600, 1'b0, '0},
    // largest frame of all: mpeg-2.5 layer ii, 160 kbit/s, 8 khz, padded
    '{32'hFFE5_EA00, 1'b1, '{1'b1, 9'd160, 16'd8000, 12'd2881}},
    // mpeg-2.5 layer i
    '{32'hFFE7_1000, 1'b0, '0},
    // reserved version: no bitrate, undivided sample rate
    '{32'hFFEB_9400, 1'b1, '{1'b1, 9'd0, 16'd48000, 12'd0}},
    // reserved layer
    '{32'hFFF9_9000, 1'b1, '{1'b1, 9'd0, 16'd44100, 12'd0}},
    // free-format bitrate index
    '{32'hFFFB_0000, 1'b1, '{1'b1, 9'd0, 16'd44100, 12'd0}},
    // bad bitrate index
    '{32'hFFFB_F000, 1'b1, '{1'b1, 9'd0, 16'd44100, 12'd0}},
    // reserved sample-rate index
    '{32'hFFFB_9C00, 1'b1, '{1'b1, 9'd128, 16'd0, 12'd0}},
    // every bit set
    '{32'hFFFF_FFFF, 1'b1, '{1'b1, 9'd0, 16'd0, 12'd0}},
    // back to all zero, now a change
    '{32'h0000_0000, 1'b0, '0},
    '{32'h8000_0000, 1'b0, '0},
    // mpeg-2.5 layer iii, lowest bitrate
    '{32'hFFE2_1400, 1'b0, '0}
  };

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [31:0] header_word = '0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        changed;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic [11:0] frame_bytes;

  // side information travelling with the item on the input
  logic        probe_fixed = 1'b0;
  frame_info_t probe_info  = '0;

  // no idling on either side while set
  bit calm = 1'b0;

  // own copy of what the block keeps between items
  logic [31:0] kept_header = '0;
  logic [8:0]  kept_kbps   = '0;
  logic [15:0] kept_rate   = '0;
  logic [11:0] kept_bytes  = '0;

  owed_frame_t owed_frames[$];
  int unsigned faults      = 0;
  int unsigned quiet_count = 0;

  mpeg_audio_header_decoder DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .header_word_i   (header_word),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .changed_o       (changed),
    .bitrate_kbps_o  (bitrate_kbps),
    .sample_rate_hz_o(sample_rate_hz),
    .frame_bytes_o   (frame_bytes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decodes one header against the kept one and updates the kept values
  function automatic frame_info_t decode_header(input logic [31:0] word);
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bidx;
    logic [1:0]  sidx;
    int unsigned kbps;
    int unsigned rate;
    int unsigned bytes;
    frame_info_t res;
    if (word[31:9] == kept_header[31:9]) begin
      res.changed = 1'b0;
      res.kbps    = kept_kbps;
      res.rate_hz = kept_rate;
      res.bytes   = kept_bytes;
      return res;
    end
    ver  = word[20:19];
    lay  = word[18:17];
    bidx = word[15:12];
    sidx = word[11:10];
    kbps = 0;
    if (ver == mahd_pkg::VerMpeg1) begin
      if (lay == mahd_pkg::LayerI) kbps = KbpsV1L1[bidx];
      else if (lay == mahd_pkg::LayerII) kbps = KbpsV1L2[bidx];
      else if (lay == mahd_pkg::LayerIII) kbps = KbpsV1L3[bidx];
    end else if (ver == mahd_pkg::VerMpeg2 || ver == mahd_pkg::VerMpeg25) begin
      if (lay == mahd_pkg::LayerI) kbps = KbpsV2L1[bidx];
      else if (lay == mahd_pkg::LayerII || lay == mahd_pkg::LayerIII) kbps = KbpsV2L23[bidx];
    end
    // half rate for mpeg-2, quarter rate for mpeg-2.5
    rate = RateHz[sidx];
    if (ver == mahd_pkg::VerMpeg2) rate = rate / 2;
    else if (ver == mahd_pkg::VerMpeg25) rate = rate / 4;
    bytes = 0;
    if (kbps != 0 && rate != 0) begin
      // layer i counts in four-byte slots
      if (lay == mahd_pkg::LayerI) bytes = ((12 * kbps * 1000) / rate + word[9]) * 4;
      else bytes = (144 * kbps * 1000) / rate + word[9];
    end
    kept_header = word;
    kept_kbps   = kbps[8:0];
    kept_rate   = rate[15:0];
    kept_bytes  = bytes[11:0];
    res.changed = 1'b1;
    res.kbps    = kept_kbps;
    res.rate_hz = kept_rate;
    res.bytes   = kept_bytes;
    return res;
  endfunction

  // mostly repeats, padding flips and well-formed headers with random fields,
  // the rest plain noise
  function automatic logic [31:0] next_header(input logic [31:0] prev);
    int unsigned pick;
    int unsigned sel;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [31:0] word;
    pick = $urandom_range(99);
    word = $urandom;
    if (pick < 30) begin
      word = {prev[31:9], word[8:0]};
    end else if (pick < 40) begin
      word = {prev[31:10], ~prev[9], word[8:0]};
    end else if (pick < 85) begin
      sel = $urandom_range(15);
      ver = (sel == 0) ? VerReserved : (sel < 6) ? mahd_pkg::VerMpeg1 :
            (sel < 11) ? mahd_pkg::VerMpeg2 : mahd_pkg::VerMpeg25;
      sel = $urandom_range(15);
      lay = (sel == 0) ? LayerReserved : (sel < 6) ? mahd_pkg::LayerI :
            (sel < 11) ? mahd_pkg::LayerII : mahd_pkg::LayerIII;
      word[31:21] = 11'h7FF;
      word[20:19] = ver;
      word[18:17] = lay;
    end
    return word;
  endfunction

  // presents one item after a random gap (none while calm) and holds it until taken
  task automatic offer(input logic [31:0] word, input logic fixed, input frame_info_t info);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    header_word <= word;
    probe_fixed <= fixed;
    probe_info  <= info;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stops sending and waits for every owed result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_frames.size() != 0) @(posedge clk);
  endtask

  task automatic note_fault(input string what, input logic [31:0] word,
                            input frame_info_t want, input frame_info_t got);
    faults++;
    if (faults <= ReportMax) begin
      $display("%s for header %h: changed %0b/%0b kbps %0d/%0d", what, word,
               want.changed, got.changed, want.kbps, got.kbps);
      $display("  rate %0d/%0d bytes %0d/%0d (expected/actual)",
               want.rate_hz, got.rate_hz, want.bytes, got.bytes);
    end
  endtask

  // receiver stalls at random, except in the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IdlePercent);
  end

  // takes in accepted items, checks results and watches for a hang
  always @(posedge clk) begin
    owed_frame_t arrived;
    owed_frame_t oldest;
    frame_info_t got;
    logic        moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      arrived.word = header_word;
      arrived.info = decode_header(header_word);
      // typed-in rows stand in for the prediction, the kept state still moves on
      if (probe_fixed) arrived.info = probe_info;
      owed_frames.push_back(arrived);
      moved = 1'b1;
    end
    if (out_valid && !out_stall) begin
      moved       = 1'b1;
      got.changed = changed;
      got.kbps    = bitrate_kbps;
      got.rate_hz = sample_rate_hz;
      got.bytes   = frame_bytes;
      if (owed_frames.size() == 0) begin
        note_fault("unexpected result", 32'h0, '0, got);
      end else begin
        oldest = owed_frames.pop_front();
        if (got.changed !== oldest.info.changed || got.kbps !== oldest.info.kbps ||
            got.rate_hz !== oldest.info.rate_hz || got.bytes !== oldest.info.bytes) begin
          note_fault("mismatch", oldest.word, oldest.info, got);
        end
      end
    end
    quiet_count = moved ? 0 : quiet_count + 1;
    if (quiet_count >= StallLimit) begin
      $display("no item moved for %0d cycles, %0d results owed", StallLimit,
               owed_frames.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [31:0] last_word;
    last_word = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed headers
    for (int r = 0; r < $size(ProbeRows); r++) begin
      offer(ProbeRows[r].word, ProbeRows[r].fixed, ProbeRows[r].info);
      last_word = ProbeRows[r].word;
    end
    settle();

    // random headers, with a calm stretch and two full drains on the way
    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 500 && n < 700);
      if (n == 250 || n == 1000) settle();
      last_word = next_header(last_word);
      offer(last_word, 1'b0, '0);
    end
    calm = 1'b0;
    settle();
    repeat (DrainCycles) @(posedge clk);

    if (faults == 0 && owed_frames.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d faults, %0d results never arrived", faults, owed_frames.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
